[design/deq_pkg.sv]
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants of the double-ended queue: store geometry,
// operation and status codes, and the controller command group.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned DW    = 64;

  typedef enum logic [2:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_REVERSE    = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic exec;      // operation beat taken this cycle
    logic load_out;  // move the looked-up words into the output register
  } cmd_t;

  // ring wrap of a sum known to stay below twice the depth
  function automatic logic [AW-1:0] wrap_idx(logic [CW:0] sum);
    logic [AW-1:0] r;
    if (sum >= (CW+1)'(DEPTH)) begin
      r = AW'(sum - (CW+1)'(DEPTH));
    end else begin
      r = AW'(sum);
    end
    return r;
  endfunction

endpackage

[design/deq_ctrl.sv]
// ----------------------------------------------------------------------------
// deq_ctrl
// Controller: takes one operation beat, waits in the write-back state for the
// lookup and a free output register, then loads the result into that register.
// ----------------------------------------------------------------------------
module deq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output deq_pkg::cmd_t cmd_o
);
  import deq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WB   = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d        = state_q;
    cmd_o.exec     = 1'b0;
    cmd_o.load_out = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.exec = 1'b1;
          state_d    = S_WB;
        end
      end
      S_WB: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[design/deq_dpath.sv]
// ----------------------------------------------------------------------------
// deq_dpath
// Datapath: ring pointers, direction flag, word store with two registered
// read ports, write forwarding and the result register.
// ----------------------------------------------------------------------------
module deq_dpath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  deq_pkg::cmd_t              cmd_i,
  input  logic [2:0]                 mode_i,
  input  logic [deq_pkg::DW-1:0]     value_i,
  output logic [deq_pkg::DW-1:0]     front_value_o,
  output logic [deq_pkg::DW-1:0]     back_value_o,
  output logic [deq_pkg::CW-1:0]     entry_count_o,
  output logic                       is_empty_o,
  output logic [1:0]                 status_o
);
  import deq_pkg::*;

  // pointer state
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic          rev_q, rev_d;

  // per-item payload
  status_e       status_q, status_d;
  logic [DW-1:0] value_q;
  logic          fwd_first_q, fwd_last_q;
  logic [DW-1:0] rd_first_q, rd_last_q;

  // store
  logic [DW-1:0] mem [DEPTH];

  logic          full, empty, we;
  logic [AW-1:0] wr_addr, first_addr, last_addr;
  logic [CW-1:0] last_off;
  logic [DW-1:0] first_w, last_w;

  assign full  = (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);

  // next pointer state for the operation on the input
  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    rev_d    = rev_q;
    status_d = ST_DONE;
    we       = 1'b0;
    wr_addr  = wrap_idx({1'b0, CW'(head_q)} + {1'b0, count_q});
    case (mode_e'(mode_i))
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          we      = 1'b1;
          count_d = count_q + CW'(1);
          // front push on a plain queue, back push on a reversed one
          if ((mode_e'(mode_i) == MODE_PUSH_FRONT) != rev_q) begin
            head_d  = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
            wr_addr = head_d;
          end
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          count_d = count_q - CW'(1);
          if ((mode_e'(mode_i) == MODE_POP_FRONT) != rev_q) begin
            head_d = wrap_idx({1'b0, CW'(head_q)} + (CW+1)'(1));
          end
        end
      end
      MODE_REVERSE: rev_d = !rev_q;
      default: ;
    endcase
  end

  // lookup addresses at the updated pointers
  assign last_off   = count_d - CW'(1);
  assign first_addr = head_d;
  assign last_addr  = wrap_idx({1'b0, CW'(head_d)} + {1'b0, last_off});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      rev_q   <= 1'b0;
    end else if (cmd_i.exec) begin
      head_q  <= head_d;
      count_q <= count_d;
      rev_q   <= rev_d;
    end
  end

  // store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && we) begin
      mem[wr_addr] <= value_i;
    end
    if (cmd_i.exec) begin
      rd_first_q <= mem[first_addr];
      rd_last_q  <= mem[last_addr];
    end
  end

  // a word written in the same beat is forwarded over the stale read data
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      value_q     <= value_i;
      status_q    <= status_d;
      fwd_first_q <= we && (wr_addr == first_addr);
      fwd_last_q  <= we && (wr_addr == last_addr);
    end
  end

  always_comb begin
    first_w = fwd_first_q ? value_q : rd_first_q;
    last_w  = fwd_last_q  ? value_q : rd_last_q;
    if (count_q == '0) begin
      first_w = '0;
      last_w  = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      front_value_o <= rev_q ? last_w : first_w;
      back_value_o  <= rev_q ? first_w : last_w;
      entry_count_o <= count_q;
      is_empty_o    <= (count_q == '0);
      status_o      <= status_q;
    end
  end

endmodule

[design/double_ended_queue.sv]
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of 64-bit words in a ring store with a head
// index, a count and a direction flag; every operation returns one result.
// ----------------------------------------------------------------------------
//
//  channel  | signals                                  | dir
//  ---------+------------------------------------------+-----
//  in       | in_valid_i, in_ready_o, mode_i, value_i  | in
//  out      | out_valid_o, out_ready_i, front_value_o,  | out
//           | back_value_o, entry_count_o, is_empty_o, |
//           | status_o                                 |
//
// in an operation beat, the accept cycle updates the pointers, writes the store
// and issues both lookups; the write-back state then loads the result into the
// output register once it is free. reset brings the queue up empty, head at
// slot zero, not reversed; store contents stay undefined until written and
// never reach the outputs before that.
// a result waiting on a stalled out channel holds the next operation in its
// lookup cycle, and in_ready_o stays low while an operation is in flight.
// ----------------------------------------------------------------------------
module double_ended_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [2:0]             mode_i,
  input  logic [deq_pkg::DW-1:0] value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [deq_pkg::DW-1:0] front_value_o,
  output logic [deq_pkg::DW-1:0] back_value_o,
  output logic [deq_pkg::CW-1:0] entry_count_o,
  output logic                   is_empty_o,
  output logic [1:0]             status_o
);
  import deq_pkg::*;

  // command group from controller to datapath
  cmd_t cmd;

  // sequencing: accept, lookup, hand over to the output register
  deq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // pointers, store and result register
  deq_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .mode_i        (mode_i),
    .value_i       (value_i),
    .front_value_o (front_value_o),
    .back_value_o  (back_value_o),
    .entry_count_o (entry_count_o),
    .is_empty_o    (is_empty_o),
    .status_o      (status_o)
  );

endmodule

[sim/double_ended_queue_tb.sv]
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// Self-checking bench for the ring-buffer deque. A behavioural ring model
// predicts front, back, count, empty flag and status for every accepted
// operation beat. Directed tests cover the empty queue, each operation,
// unused modes and overflow. A long random mix then drives fill and drain
// runs, with random gaps on the operation channel and stalls on the result
// channel.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;
  import deq_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned RANDOM_BEATS = 1230;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned MAX_REPORTS  = 100;
  // modes 5 to 7 carry no operation
  localparam logic [2:0]  MODE_SPARE_LO = 3'd5;
  localparam logic [2:0]  MODE_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [DW-1:0] front;
    logic [DW-1:0] back;
    logic [CW-1:0] count;
    logic          empty;
    logic [1:0]    status;
  } deq_result_t;

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_ready_o;
  logic [2:0]    mode_i;
  logic [DW-1:0] value_i;
  logic          out_valid_o;
  logic          out_ready_i;
  logic [DW-1:0] front_value_o;
  logic [DW-1:0] back_value_o;
  logic [CW-1:0] entry_count_o;
  logic          is_empty_o;
  logic [1:0]    status_o;

  double_ended_queue DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .front_value_o (front_value_o),
    .back_value_o  (back_value_o),
    .entry_count_o (entry_count_o),
    .is_empty_o    (is_empty_o),
    .status_o      (status_o)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // ring model: physical store, head slot, held count and direction flag
  // ---------------------------------------------------------------------------
  logic [DW-1:0] ring [DEPTH];
  logic [AW-1:0] head_slot;
  logic [CW-1:0] held;
  logic          flipped;

  // results still owed by the block, oldest first
  deq_result_t   owed_results [$];
  deq_result_t   want;

  int unsigned   errors;
  int unsigned   cycle_count;
  int unsigned   beats_sent;
  int unsigned   results_seen;
  int unsigned   full_drops;
  int unsigned   empty_pops;
  int unsigned   flips;
  bit            calm;  // no gaps on either side while set

  // apply one operation to the ring model and return the result it should give
  function automatic deq_result_t deq_apply(logic [2:0] op, logic [DW-1:0] word);
    deq_result_t   r;
    logic          at_head;
    logic [DW-1:0] first_w;
    logic [DW-1:0] last_w;
    r.status = ST_DONE;
    case (op)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        // the logical front is the physical head unless reversed
        at_head = (op == MODE_PUSH_FRONT) ? !flipped : flipped;
        if (held == CW'(DEPTH)) begin
          r.status = ST_FULL;
          full_drops++;
        end else begin
          if (at_head) begin
            head_slot = AW'((head_slot + DEPTH - 1) % DEPTH);
            ring[head_slot] = word;
          end else begin
            ring[AW'((head_slot + held) % DEPTH)] = word;
          end
          held = held + CW'(1);
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK: begin
        at_head = (op == MODE_POP_FRONT) ? !flipped : flipped;
        if (held == '0) begin
          r.status = ST_EMPTY;
          empty_pops++;
        end else begin
          if (at_head) head_slot = AW'((head_slot + 1) % DEPTH);
          held = held - CW'(1);
        end
      end
      MODE_REVERSE: begin
        flipped = !flipped;
        flips++;
      end
      default: ;
    endcase
    first_w = '0;
    last_w  = '0;
    if (held != '0) begin
      first_w = ring[head_slot];
      last_w  = ring[AW'((head_slot + held - 1) % DEPTH)];
    end
    r.front = flipped ? last_w : first_w;
    r.back  = flipped ? first_w : last_w;
    r.count = held;
    r.empty = (held == '0);
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // words with a bias towards the extremes and single set bits
  function automatic logic [DW-1:0] random_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      2:       return DW'(1) << $urandom_range(0, DW - 1);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // push_pct sets the push share among pushes and pops
  function automatic logic [2:0] random_op(int unsigned push_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return MODE_SPARE_LO + 3'($urandom_range(0, MODE_SPARE_HI - MODE_SPARE_LO));
    if (r < 10) return MODE_REVERSE;
    if ($urandom_range(0, 99) < push_pct) begin
      return $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
    end
    return $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK;
  endfunction

  // ---------------------------------------------------------------------------
  // operation channel: called at a falling edge, returns at a falling edge;
  // valid stays high into the next beat when no gap is drawn
  // ---------------------------------------------------------------------------
  task automatic send_op(input logic [2:0] op, input logic [DW-1:0] word);
    int unsigned gap;
    in_valid_i <= 1'b1;
    mode_i     <= op;
    value_i    <= word;
    do @(posedge clk_i); while (!in_ready_o);
    owed_results.push_back(deq_apply(op, word));
    beats_sent++;
    @(negedge clk_i);
    gap = idle_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // ---------------------------------------------------------------------------
  // result channel: random stalls, checked at the rising edge
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      n = idle_gap();
      if (n != 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(0, 10)) @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (owed_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: result beat with nothing expected (front %h back %h count %0d)",
                   $time, front_value_o, back_value_o, entry_count_o);
        end
      end else begin
        want = owed_results.pop_front();
        if (front_value_o !== want.front) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("%0t: front_value expected %h got %h", $time, want.front, front_value_o);
          end
        end
        if (back_value_o !== want.back) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("%0t: back_value expected %h got %h", $time, want.back, back_value_o);
          end
        end
        if (entry_count_o !== want.count) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("%0t: entry_count expected %0d got %0d", $time, want.count, entry_count_o);
          end
        end
        if (is_empty_o !== want.empty) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("%0t: is_empty expected %b got %b", $time, want.empty, is_empty_o);
          end
        end
        if (status_o !== want.status) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, status_o);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed",
               cycle_count, owed_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // pops on an empty queue are ignored, reverse still toggles the flag
  task automatic test_empty_queue();
    send_op(MODE_POP_FRONT, random_word());
    send_op(MODE_POP_BACK, random_word());
    send_op(MODE_REVERSE, random_word());
    send_op(MODE_POP_FRONT, random_word());
    send_op(MODE_REVERSE, random_word());
  endtask

  // every operation with extreme words, both with and without reversal
  task automatic test_basic_ops();
    send_op(MODE_PUSH_FRONT, '0);
    send_op(MODE_PUSH_BACK, '1);
    send_op(MODE_PUSH_FRONT, {1'b1, {(DW-1){1'b0}}});
    send_op(MODE_PUSH_BACK, DW'(1));
    send_op(MODE_REVERSE, '0);
    send_op(MODE_POP_FRONT, '1);
    send_op(MODE_PUSH_FRONT, 64'h5555_5555_5555_5555);
    send_op(MODE_PUSH_BACK, 64'hAAAA_AAAA_AAAA_AAAA);
    send_op(MODE_POP_BACK, '0);
    send_op(MODE_REVERSE, '1);
    send_op(MODE_POP_BACK, '0);
    send_op(MODE_POP_FRONT, '0);
    send_op(MODE_POP_FRONT, '0);
    send_op(MODE_POP_BACK, '0);
  endtask

  // unused modes leave the state alone and report done
  task automatic test_unused_modes();
    logic [2:0] op;
    send_op(MODE_PUSH_BACK, random_word());
    for (op = MODE_SPARE_LO; op != MODE_SPARE_HI; op++) send_op(op, random_word());
    send_op(MODE_SPARE_HI, random_word());
    send_op(MODE_POP_FRONT, '0);
  endtask

  // fill from both ends until full, overflow, then reverse and pop across the wrap
  task automatic test_full_queue();
    int unsigned i;
    for (i = 0; i < DEPTH; i++) begin
      send_op($urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK, random_word());
    end
    send_op(MODE_PUSH_FRONT, random_word());
    send_op(MODE_PUSH_BACK, random_word());
    send_op(MODE_REVERSE, '0);
    send_op(MODE_PUSH_BACK, random_word());
    send_op(MODE_POP_FRONT, '0);
    send_op(MODE_PUSH_FRONT, random_word());
  endtask

  // runs of fill-heavy, drain-heavy and balanced traffic, some without gaps
  task automatic test_random_mix();
    int unsigned left;
    int unsigned run;
    int unsigned push_pct;
    int unsigned i;
    left = RANDOM_BEATS;
    while (left != 0) begin
      run = $urandom_range(30, 150);
      if (run > left) run = left;
      case ($urandom_range(0, 2))
        0:       push_pct = 85;
        1:       push_pct = 15;
        default: push_pct = 50;
      endcase
      calm = ($urandom_range(0, 3) == 0);
      for (i = 0; i < run; i++) send_op(random_op(push_pct), random_word());
      left -= run;
    end
    calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    mode_i      = MODE_PUSH_FRONT;
    value_i     = '0;
    out_ready_i = 1'b0;
    head_slot   = '0;
    held        = '0;
    flipped     = 1'b0;
    errors      = 0;
    cycle_count = 0;
    beats_sent  = 0;
    results_seen = 0;
    full_drops  = 0;
    empty_pops  = 0;
    flips       = 0;
    calm        = 1'b0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_queue();
    test_basic_ops();
    test_unused_modes();
    test_full_queue();
    test_random_mix();
    in_valid_i <= 1'b0;

    // let the last results drain, then watch for strays
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d operation beats, %0d results checked, %0d errors",
             beats_sent, results_seen, errors);
    $display("%0d pushes dropped while full, %0d pops on an empty queue, %0d reversals",
             full_drops, empty_pops, flips);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[filelist.f]
design/deq_pkg.sv
design/deq_ctrl.sv
design/deq_dpath.sv
design/double_ended_queue.sv
sim/double_ended_queue_tb.sv
